FILE: sv/sliding_window_median_macros.svh
// Assertion macros of the sliding-window median RTL, used by the datapath swm_dp.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH
`ifndef ASSERT_OFF
`define SWM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SWM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWM_ASSERT(label, clk, rst, prop, msg)
`define SWM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: sv/swm_pkg.sv
// Shared types and constants of the sliding-window median filter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package swm_pkg;

  localparam int S_TDATA_W  = 32;
  localparam int MEDIAN_W   = 33;
  localparam int M_TDATA_W  = 40;
  localparam int WS_W       = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Word index of the window size register (paddr[2]).
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic [WS_W-1:0] WS_RESET = 5'd3;

  typedef struct packed {
    logic load_sample;
    logic ram_rd;
    logic remove;
    logic insert;
    logic load_hi;
    logic load_out;
  } swm_cmd_t;

  typedef struct packed {
    logic full;
    logic result_due;
    logic out_free;
  } swm_status_t;

endpackage
`default_nettype wire

FILE: sv/swm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the arrival-order ring; no dependencies.
`default_nettype none
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/swm_dp.sv
// Datapath of the sliding-window median filter: arrival ring, sorted cell row,
// fill and oldest counters, median adder and output register. Uses swm_pkg, swm_ram.
`default_nettype none
`include "sliding_window_median_macros.svh"
module swm_dp #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [swm_pkg::WS_W-1:0]       window_size,
  input  wire logic                           cfg_wr,
  input  wire logic [swm_pkg::S_TDATA_W-1:0]  s_tdata,
  output      logic                           m_tvalid,
  input  wire logic                           m_tready,
  output      logic [swm_pkg::M_TDATA_W-1:0]  m_tdata,
  input  wire swm_pkg::swm_cmd_t              cmd,
  output      swm_pkg::swm_status_t           status
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = $clog2(MAX_WINDOW);

  logic [CW-1:0]                 w_eff;
  logic [CW-1:0]                 fill;
  logic [CW-1:0]                 n_ins;
  logic [AW-1:0]                 oldest;
  logic [AW-1:0]                 hi_idx;
  logic [AW-1:0]                 lo_idx;
  logic [AW-1:0]                 med_idx;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SAMPLE_BITS-1:0] med_hi;
  logic signed [SAMPLE_BITS-1:0] med_rd;
  logic signed [SAMPLE_BITS-1:0] cells      [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cells_next [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] prev_cell  [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] up_cell    [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         gt;
  logic [MAX_WINDOW-1:0]         prev_gt;
  logic [SAMPLE_BITS:0]          sum;
  logic [MEDIAN_W-1:0]           median_q;

  // Out-of-range window sizes clamp: zero acts as one, large values as MAX_WINDOW.
  always_comb begin
    if (window_size == '0) begin
      w_eff = CW'(1);
    end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = CW'(window_size);
    end
  end

  assign full   = (fill == w_eff);
  assign n_ins  = full ? (w_eff - CW'(1)) : fill;
  assign hi_idx = AW'(w_eff >> 1);
  assign lo_idx = AW'((w_eff - CW'(1)) >> 1);

  assign status.full       = full;
  assign status.result_due = full || ((fill + CW'(1)) == w_eff);
  assign status.out_free   = !m_tvalid || m_tready;

  swm_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.insert),
    .waddr(full ? oldest : AW'(fill)),
    .wdata(sample_q),
    .re   (cmd.ram_rd),
    .raddr(oldest),
    .rdata(old_val)
  );

  // Each cell decides from its own value and its neighbors. Removal shifts down
  // every held cell at or above the departing value; insertion shifts up every
  // held cell above the new one, which lands in the first gap.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    assign gt[i] = (CW'(i) < n_ins) && (cells[i] > sample_q);

    if (i == 0) begin : g_first
      assign prev_gt[i]   = 1'b0;
      assign prev_cell[i] = cells[i];
    end else begin : g_rest
      assign prev_gt[i]   = gt[i-1];
      assign prev_cell[i] = cells[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign up_cell[i] = cells[i];
    end else begin : g_inner
      assign up_cell[i] = cells[i+1];
    end

    always_comb begin
      cells_next[i] = cells[i];
      if (cmd.remove) begin
        if ((CW'(i) < w_eff) && (cells[i] >= old_val)) begin
          cells_next[i] = up_cell[i];
        end
      end else if (cmd.insert && (CW'(i) <= n_ins)) begin
        if (prev_gt[i]) begin
          cells_next[i] = prev_cell[i];
        end else if (gt[i] || (CW'(i) == n_ins)) begin
          cells_next[i] = sample_q;
        end
      end
    end
  end

  assign med_idx = cmd.load_hi ? hi_idx : lo_idx;
  assign med_rd  = cells[med_idx];
  assign sum     = {med_rd[SAMPLE_BITS-1], med_rd} + {med_hi[SAMPLE_BITS-1], med_hi};

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (cmd.load_sample) begin
      sample_q <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (cmd.load_hi) begin
      med_hi <= med_rd;
    end
    if (cmd.load_out) begin
      median_q <= MEDIAN_W'($unsigned(sum));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      oldest   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        fill   <= '0;
        oldest <= '0;
      end else if (cmd.insert) begin
        if (full) begin
          oldest <= ((CW'(oldest) + CW'(1)) == w_eff) ? '0 : oldest + AW'(1);
        end else begin
          fill <= fill + CW'(1);
        end
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(M_TDATA_W - MEDIAN_W){1'b0}}, median_q};

  `SWM_ASSERT(a_fill_in_window, clk, rst, (fill <= w_eff), "fill count exceeds window size")
  `SWM_ASSERT(a_oldest_only_full, clk, rst, ((oldest != '0) |-> full), "ring wrapped before window filled")
  `SWM_ASSERT(a_remove_only_full, clk, rst, (cmd.remove |-> full), "removal from a window that is not full")
  `SWM_ASSERT_ALWAYS(a_reset_empties, clk, (rst |=> (fill == '0 && oldest == '0)), "reset left samples in the window")

endmodule
`default_nettype wire

FILE: sv/swm_ctrl.sv
// Controller of the sliding-window median filter: sequences read and remove
// (window full), insert, and the two median reads (result due). Uses swm_pkg.
`default_nettype none
module swm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire swm_pkg::swm_status_t status,
  output      swm_pkg::swm_cmd_t    cmd
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    REMOVE,
    INSERT,
    MED_HI,
    MED_LO
  } state_t;

  state_t state;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.load_sample = s_tvalid;
        cmd.ram_rd      = s_tvalid && status.full;
      end
      REMOVE: begin
        cmd.remove = 1'b1;
      end
      INSERT: begin
        cmd.insert = 1'b1;
      end
      MED_HI: begin
        cmd.load_hi = 1'b1;
      end
      MED_LO: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= status.full ? REMOVE : INSERT;
          end
        end
        REMOVE: begin
          state <= INSERT;
        end
        INSERT: begin
          state <= status.result_due ? MED_HI : IDLE;
        end
        MED_HI: begin
          state <= MED_LO;
        end
        MED_LO: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/sliding_window_median.sv
// Sliding-window median filter: takes one signed sample per item and, once the
// window is full, returns twice the window median for every sample. An item
// that leaves the window short of full is only inserted; the item that fills it
// also gets two reads of the middle cells; once the window is full, each item
// reads the departing sample from the ring RAM, removes it and inserts the new
// one in the sorted cell row, then reads the middle cells twice through one
// shared read mux. A finished result waits in the output register while the
// next item is taken. Writing window_size (APB word 0) empties the window. No
// clearing pass runs after reset. Depends on swm_pkg, swm_ctrl and swm_dp.
`default_nettype none
module sliding_window_median #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [swm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [swm_pkg::APB_DATA_W-1:0]   pwdata,
  output      logic [swm_pkg::APB_DATA_W-1:0]   prdata,
  output      logic                             pready,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  input  wire logic [swm_pkg::S_TDATA_W-1:0]    s_tdata,  // [31:0] sample
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  output      logic [swm_pkg::M_TDATA_W-1:0]    m_tdata   // [32:0] median_twice, [39:33] zero
);
  import swm_pkg::*;

  logic [WS_W-1:0] window_size;
  logic            cfg_wr;
  swm_cmd_t        cmd;
  swm_status_t     status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ?
                  {{(APB_DATA_W - WS_W){1'b0}}, window_size} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
    end else if (cfg_wr) begin
      window_size <= pwdata[WS_W-1:0];
    end
  end

  swm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  swm_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .window_size(window_size),
    .cfg_wr     (cfg_wr),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for sliding_window_median: a stream of signed samples
// is checked against a sorted-window predictor, with register writes between phases.
// Depends on swm_pkg and the sliding_window_median RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swm_pkg::*;

  localparam int MAX_WIN = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SHOWN_ERRORS = 10;
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = {~REG_WINDOW_SIZE, 2'b00};
  localparam logic [31:0] SAMPLE_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // [31:0] sample
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // [32:0] median_twice, [39:33] zero

  // Predictor state: window register, arrival ring and sorted copy of the window.
  logic [WS_W-1:0] win_reg = WS_RESET;
  logic signed [31:0] arrival_ring_q [MAX_WIN];
  logic signed [31:0] sorted_q [MAX_WIN];
  int unsigned fill_n = 0;
  int unsigned oldest_idx = 0;
  logic signed [MEDIAN_W-1:0] expected_medians[$];

  int err_count = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  sliding_window_median u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_median test failed");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (err_count < SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned active_window();
    if (win_reg == '0) return 1;
    if (win_reg > MAX_WIN) return MAX_WIN;
    return 32'(win_reg);
  endfunction

  function automatic void sorted_put(input logic signed [31:0] v, input int unsigned n);
    int unsigned i;
    i = n;
    while (i > 0 && sorted_q[i-1] > v) begin
      sorted_q[i] = sorted_q[i-1];
      i--;
    end
    sorted_q[i] = v;
  endfunction

  // Removes exactly one entry equal to v, so duplicates stay counted correctly.
  function automatic void sorted_drop(input logic signed [31:0] v, input int unsigned n);
    int unsigned i;
    i = 0;
    while (i < n && sorted_q[i] != v) i++;
    if (i >= n) return;
    while (i + 1 < n) begin
      sorted_q[i] = sorted_q[i+1];
      i++;
    end
  endfunction

  function automatic void advance_window(input logic [31:0] raw);
    int unsigned w;
    logic signed [31:0] s;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [MEDIAN_W-1:0] twice;
    w = active_window();
    s = raw;
    if (fill_n > w) fill_n = w;
    if (fill_n < w) begin
      arrival_ring_q[fill_n] = s;
      sorted_put(s, fill_n);
      fill_n++;
      if (fill_n < w) return;
    end else begin
      if (oldest_idx >= w) oldest_idx = 0;
      sorted_drop(arrival_ring_q[oldest_idx], w);
      sorted_put(s, w - 1);
      arrival_ring_q[oldest_idx] = s;
      oldest_idx++;
      if (oldest_idx >= w) oldest_idx = 0;
    end
    if (w[0]) begin
      twice = {sorted_q[w/2], 1'b0};
    end else begin
      lo = sorted_q[w/2-1];
      hi = sorted_q[w/2];
      twice = {lo[31], lo} + {hi[31], hi};
    end
    expected_medians = {expected_medians, twice};
  endfunction

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    logic signed [MEDIAN_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_medians.size() == 0) begin
        report_error($sformatf("unexpected result median_twice=%0d",
                               $signed(m_tdata[MEDIAN_W-1:0])));
      end else begin
        want = expected_medians.pop_front();
        if (m_tdata[MEDIAN_W-1:0] !== want)
          report_error($sformatf("median_twice expected %0d got %0d", want,
                                 $signed(m_tdata[MEDIAN_W-1:0])));
      end
    end
  end

  // Receiver back-pressure: random stalls, none while no_idle is set.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 9) < 3) stall_left = pick_gap();
      end
    end
  end

  // Valid stays high after an item so back-to-back items need no extra step;
  // release_stream lowers it whenever the sender stops.
  task automatic send_sample(input logic [31:0] v);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    do @(posedge clk); while (!s_tready);
    advance_window(v);
  endtask

  task automatic release_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Waits until every expected result has come, then lets an item that
  // produces no result finish before the block is touched again.
  task automatic drain();
    release_stream();
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the window size (upper data bits are don't-care) and reads it back.
  task automatic set_window(input logic [31:0] data);
    logic [31:0] readback;
    apb_write(ADDR_WINDOW_SIZE, data);
    win_reg = data[WS_W-1:0];
    fill_n = 0;
    oldest_idx = 0;
    apb_read(ADDR_WINDOW_SIZE, readback);
    if (readback !== 32'(win_reg))
      report_error($sformatf("window_size read expected %0d got %0d", win_reg, readback));
  endtask

  task automatic test_reset_window();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample('1);
    drain();
  endtask

  task automatic test_extreme_sums();
    set_window(2);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    drain();
  endtask

  task automatic test_duplicates();
    set_window(4);
    send_sample(5);
    send_sample(5);
    send_sample(5);
    send_sample(-3);
    send_sample(5);
    send_sample(-3);
    drain();
  endtask

  task automatic test_window_writes();
    // Size zero behaves as a window of one.
    set_window(32'hffff_ffe0);
    send_sample(32'h1234_5678);
    send_sample(32'hedcb_a987);
    drain();
    // A write to an unmapped word must not disturb the half-filled window.
    set_window(2);
    send_sample(9);
    drain();
    apb_write(ADDR_UNMAPPED, 1);
    send_sample(-11);
    drain();
    // Rewriting the size empties the window again.
    send_sample(7);
    drain();
    set_window(2);
    send_sample(100);
    drain();
    send_sample(-100);
    drain();
  endtask

  task automatic test_random_stream();
    logic [4:0] sizes [10];
    int unsigned count;
    sizes = '{5'd16, 5'd1, 5'd31, 5'd7, 5'd0, 5'd17, 5'd2, 5'd12, 5'd15, 5'd8};
    for (int p = 0; p < 10; p++) begin
      if (p >= 7) sizes[p] = 5'($urandom_range(0, 31));
      set_window(($urandom & 32'hffff_ffe0) | 32'(sizes[p]));
      no_idle = (p == 2 || p == 6);
      count = $urandom_range(45, 65);
      for (int unsigned k = 0; k < count; k++) send_sample(pick_sample());
      drain();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_window();
    test_extreme_sums();
    test_duplicates();
    test_window_writes();
    test_random_stream();
    if (err_count == 0) begin
      $display("sliding_window_median test passed");
    end else begin
      $display("sliding_window_median test failed");
    end
    $finish;
  end

endmodule
